FILE: rtl/core/hbe_pkg.sv
// Shared constants and types for the backbone hydrogen-bond energy block.
`timescale 1ns / 1ps
package hbe_pkg;

  localparam int COORD_BITS_DEF = 21;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CUTOFF   = 2'd0,
    CFG_FLOOR    = 2'd1,
    CFG_MIN_DIST = 2'd2
  } cfg_idx_t;

  localparam int CUTOFF_W   = 15;
  localparam int FLOOR_W    = 16;
  localparam int MIN_DIST_W = 12;
  localparam int ENERGY_W   = 16;

  localparam logic signed [CUTOFF_W-1:0] CUTOFF_RST   = -15'sd500;
  localparam logic signed [FLOOR_W-1:0]  FLOOR_RST    = -16'sd9900;
  localparam logic [MIN_DIST_W-1:0]      MIN_DIST_RST = 12'd500;
  localparam logic signed [ENERGY_W-1:0] ENERGY_MAX   = 16'sd32767;

  // Charge constant in milli-angstrom units, scaled by 2^FRAC_BITS
  localparam int FRAC_BITS = 16;
  localparam longint unsigned Q_NUM = 64'd1827667968000;

  localparam int DIST_LAT = 3;
  localparam int SQ_LIMIT = 64;

endpackage

FILE: rtl/core/hbe_dist.sv
// Squared distance between two atoms: difference, square, saturating sum.
`timescale 1ns / 1ps
module hbe_dist #(
  parameter int COORD_BITS = 21,
  parameter int SQW        = 44
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] p_a [3],
  input  logic signed [COORD_BITS-1:0] q_a [3],
  output logic [SQW-1:0]               sq_out
);
  import hbe_pkg::*;

  localparam int PW   = 2 * COORD_BITS;
  localparam int SUMW = PW + 2;

  logic [COORD_BITS-1:0] absd_r [3];
  logic [COORD_BITS-1:0] absd_nxt [3];
  logic [PW-1:0]         prod_r [3];
  logic [PW-1:0]         prod_nxt [3];
  logic [SUMW-1:0]       sum_full;
  logic [SQW-1:0]        sq_r;
  logic [SQW-1:0]        sq_nxt;

  always_comb begin
    logic signed [COORD_BITS:0] diff;
    for (int i = 0; i < 3; i++) begin
      diff = {p_a[i][COORD_BITS-1], p_a[i]} - {q_a[i][COORD_BITS-1], q_a[i]};
      absd_nxt[i] = diff[COORD_BITS] ? COORD_BITS'(-diff) : diff[COORD_BITS-1:0];
      prod_nxt[i] = absd_r[i] * absd_r[i];
    end
  end

  assign sum_full = SUMW'(prod_r[0]) + SUMW'(prod_r[1]) + SUMW'(prod_r[2]);

  generate
    if (SUMW > SQW) begin : g_sat
      assign sq_nxt = (|sum_full[SUMW-1:SQW]) ? '1 : sum_full[SQW-1:0];
    end else begin : g_nosat
      assign sq_nxt = sum_full[SQW-1:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        absd_r[i] <= absd_nxt[i];
        prod_r[i] <= prod_nxt[i];
      end
      sq_r <= sq_nxt;
    end
  end

  assign sq_out = sq_r;

endmodule

FILE: rtl/core/hbe_sqrt.sv
// Pipelined square root, one root bit per stage, rounded to nearest.
`timescale 1ns / 1ps
module hbe_sqrt #(
  parameter int SQW = 44
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [SQW-1:0]       x_in,
  output logic [SQW/2:0]       d_out
);
  import hbe_pkg::*;

  localparam int RW   = SQW / 2;
  localparam int REMW = RW + 1;
  localparam int TW   = RW + 3;
  localparam int DW   = RW + 1;

  logic [REMW-1:0] rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [SQW-1:0]  x_r    [RW];
  logic [DW-1:0]   d_r;

  genvar s;
  generate
    for (s = 0; s < RW; s++) begin : g_stage
      logic [REMW-1:0] rem_src;
      logic [RW-1:0]   root_src;
      logic [SQW-1:0]  x_src;
      logic [TW-1:0]   t;
      logic [TW-1:0]   trial;
      logic            ge;
      logic [TW-1:0]   diff;

      if (s == 0) begin : g_first
        assign rem_src  = '0;
        assign root_src = '0;
        assign x_src    = x_in;
      end else begin : g_next
        assign rem_src  = rem_r[s-1];
        assign root_src = root_r[s-1];
        assign x_src    = x_r[s-1];
      end

      assign t     = {rem_src, x_src[SQW-1:SQW-2]};
      assign trial = TW'({root_src, 2'b01});
      assign ge    = (t >= trial);
      assign diff  = t - trial;

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s]  <= ge ? diff[REMW-1:0] : t[REMW-1:0];
          root_r[s] <= {root_src[RW-2:0], ge};
          x_r[s]    <= x_src << 2;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= {1'b0, root_r[RW-1]} +
             DW'(rem_r[RW-1] > {1'b0, root_r[RW-1]});
    end
  end

  assign d_out = d_r;

endmodule

FILE: rtl/core/hbe_div.sv
// Pipelined restoring divider: rounded charge constant over a distance.
`timescale 1ns / 1ps
module hbe_div #(
  parameter int DW = 23,
  parameter int NB = 41
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] d_in,
  output logic [NB-1:0] q_out
);
  import hbe_pkg::*;

  logic [NB-1:0] num_r;
  logic [DW-1:0] dv0_r;
  logic [DW-1:0] p_r  [NB];
  logic [NB-1:0] nq_r [NB];
  logic [DW-1:0] dv_r [NB];

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= NB'(Q_NUM + 64'(d_in >> 1));
      dv0_r <= d_in;
    end
  end

  genvar k;
  generate
    for (k = 0; k < NB; k++) begin : g_stage
      logic [DW-1:0] p_src;
      logic [NB-1:0] nq_src;
      logic [DW-1:0] dv_src;
      logic [DW:0]   t;
      logic [DW:0]   diff;
      logic          ge;

      if (k == 0) begin : g_first
        assign p_src  = '0;
        assign nq_src = num_r;
        assign dv_src = dv0_r;
      end else begin : g_next
        assign p_src  = p_r[k-1];
        assign nq_src = nq_r[k-1];
        assign dv_src = dv_r[k-1];
      end

      assign t    = {p_src, nq_src[NB-1]};
      assign ge   = (t >= {1'b0, dv_src});
      assign diff = t - {1'b0, dv_src};

      always_ff @(posedge clk) begin
        if (en) begin
          p_r[k]  <= ge ? diff[DW-1:0] : t[DW-1:0];
          nq_r[k] <= {nq_src[NB-2:0], ge};
          dv_r[k] <= dv_src;
        end
      end
    end
  endgenerate

  assign q_out = nq_r[NB-1];

endmodule

FILE: rtl/core/backbone_hbond_energy.sv
// Backbone hydrogen-bond energy: top level with distance, root, divide and energy stages.
//
// Usage: an item is the N, H, C and O coordinates of one donor/acceptor pair,
// taken on the in_ channel when in_valid and in_ready are both high. One result
// beat (out_energy, out_is_bond) leaves on the out_ channel per item, in order.
// Registers (cutoff, floor, minimum distance) are written on the cfg_ channel,
// which is always ready; write them only while no item is in flight.
// Stages: squared distance, square root, division, energy sum and rounding, then
// the output register; with 21-bit coordinates that is 3 + 23 + 42 + 2 + 1 = 71
// register stages.
// Throughput: one item per cycle while the output does not stall; every stage
// before the output register is one compare-subtract, one multiplier or one add.
// Reset: rst_n low clears all valid bits, the output valid included, and loads
// the register defaults (cutoff -500, floor -9900, minimum distance 500).
// Stall: while out_ready is low with a result waiting and the last stage full,
// the whole pipeline holds, bubbles included, and in_ready drops.
`timescale 1ns / 1ps
module backbone_hbond_energy #(
  parameter int COORD_BITS = hbe_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COORD_BITS-1:0]      in_n_x,
  input  logic signed [COORD_BITS-1:0]      in_n_y,
  input  logic signed [COORD_BITS-1:0]      in_n_z,
  input  logic signed [COORD_BITS-1:0]      in_h_x,
  input  logic signed [COORD_BITS-1:0]      in_h_y,
  input  logic signed [COORD_BITS-1:0]      in_h_z,
  input  logic signed [COORD_BITS-1:0]      in_c_x,
  input  logic signed [COORD_BITS-1:0]      in_c_y,
  input  logic signed [COORD_BITS-1:0]      in_c_z,
  input  logic signed [COORD_BITS-1:0]      in_o_x,
  input  logic signed [COORD_BITS-1:0]      in_o_y,
  input  logic signed [COORD_BITS-1:0]      in_o_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [hbe_pkg::ENERGY_W-1:0] out_energy,
  output logic                              out_is_bond,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hbe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hbe_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import hbe_pkg::*;

  localparam int SQW_FULL = 2 * COORD_BITS + 2;
  localparam int SQW      = (SQW_FULL > SQ_LIMIT) ? SQ_LIMIT : SQW_FULL;
  localparam int RW       = SQW / 2;
  localparam int DW       = RW + 1;
  localparam int SQ_LAT   = RW + 1;
  localparam int NB       = $clog2(Q_NUM + (64'd1 << (DW - 2)) + 64'd1);
  localparam int DIV_LAT  = NB + 1;
  localparam int SW       = NB + 3;
  localparam int EW       = SW - FRAC_BITS;
  localparam int LAT      = DIST_LAT + SQ_LAT + DIV_LAT + 2;
  localparam int CL       = DIV_LAT + 2;
  localparam int CMPW     = (DW > MIN_DIST_W) ? DW + 1 : MIN_DIST_W + 1;

  logic signed [CUTOFF_W-1:0] cutoff_r, cutoff_nxt;
  logic signed [FLOOR_W-1:0]  floor_r, floor_nxt;
  logic [MIN_DIST_W-1:0]      min_dist_r, min_dist_nxt;

  logic en;
  logic [LAT-1:0] vld_r;
  logic [CL-1:0]  close_r;

  logic signed [COORD_BITS-1:0] n_a [3];
  logic signed [COORD_BITS-1:0] h_a [3];
  logic signed [COORD_BITS-1:0] c_a [3];
  logic signed [COORD_BITS-1:0] o_a [3];

  logic [SQW-1:0] sq_ho, sq_hc, sq_nc, sq_no;
  logic [DW-1:0]  d_ho, d_hc, d_nc, d_no;
  logic [NB-1:0]  t_ho, t_hc, t_nc, t_no;
  logic           close_nxt;

  logic signed [SW-1:0] s_a_r;
  logic signed [SW-1:0] rnd;
  logic signed [EW-1:0] e_b_r;
  logic signed [EW-1:0] e_sel;
  logic signed [EW-1:0] e_fin;
  logic signed [EW-1:0] floor_ext;

  logic                       out_valid_r, out_valid_nxt;
  logic signed [ENERGY_W-1:0] out_energy_r;
  logic                       out_is_bond_r;

  // configuration
  always_comb begin
    cutoff_nxt   = cutoff_r;
    floor_nxt    = floor_r;
    min_dist_nxt = min_dist_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CUTOFF:   cutoff_nxt   = cfg_data[CUTOFF_W-1:0];
        CFG_FLOOR:    floor_nxt    = cfg_data[FLOOR_W-1:0];
        CFG_MIN_DIST: min_dist_nxt = cfg_data[MIN_DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r   <= CUTOFF_RST;
      floor_r    <= FLOOR_RST;
      min_dist_r <= MIN_DIST_RST;
    end else begin
      cutoff_r   <= cutoff_nxt;
      floor_r    <= floor_nxt;
      min_dist_r <= min_dist_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  // hold everything while the output beat waits and the last stage is full
  assign en       = !vld_r[LAT-1] || !out_valid_r || out_ready;
  assign in_ready = en;

  assign n_a[0] = in_n_x; assign n_a[1] = in_n_y; assign n_a[2] = in_n_z;
  assign h_a[0] = in_h_x; assign h_a[1] = in_h_y; assign h_a[2] = in_h_z;
  assign c_a[0] = in_c_x; assign c_a[1] = in_c_y; assign c_a[2] = in_c_z;
  assign o_a[0] = in_o_x; assign o_a[1] = in_o_y; assign o_a[2] = in_o_z;

  hbe_dist #(.COORD_BITS(COORD_BITS), .SQW(SQW)) u_dist_ho (
    .clk(clk), .en(en), .p_a(h_a), .q_a(o_a), .sq_out(sq_ho));
  hbe_dist #(.COORD_BITS(COORD_BITS), .SQW(SQW)) u_dist_hc (
    .clk(clk), .en(en), .p_a(h_a), .q_a(c_a), .sq_out(sq_hc));
  hbe_dist #(.COORD_BITS(COORD_BITS), .SQW(SQW)) u_dist_nc (
    .clk(clk), .en(en), .p_a(n_a), .q_a(c_a), .sq_out(sq_nc));
  hbe_dist #(.COORD_BITS(COORD_BITS), .SQW(SQW)) u_dist_no (
    .clk(clk), .en(en), .p_a(n_a), .q_a(o_a), .sq_out(sq_no));

  hbe_sqrt #(.SQW(SQW)) u_sqrt_ho (.clk(clk), .en(en), .x_in(sq_ho), .d_out(d_ho));
  hbe_sqrt #(.SQW(SQW)) u_sqrt_hc (.clk(clk), .en(en), .x_in(sq_hc), .d_out(d_hc));
  hbe_sqrt #(.SQW(SQW)) u_sqrt_nc (.clk(clk), .en(en), .x_in(sq_nc), .d_out(d_nc));
  hbe_sqrt #(.SQW(SQW)) u_sqrt_no (.clk(clk), .en(en), .x_in(sq_no), .d_out(d_no));

  assign close_nxt =
    (d_ho == '0) || (CMPW'(d_ho) < CMPW'(min_dist_r)) ||
    (d_hc == '0) || (CMPW'(d_hc) < CMPW'(min_dist_r)) ||
    (d_nc == '0) || (CMPW'(d_nc) < CMPW'(min_dist_r)) ||
    (d_no == '0) || (CMPW'(d_no) < CMPW'(min_dist_r));

  hbe_div #(.DW(DW), .NB(NB)) u_div_ho (.clk(clk), .en(en), .d_in(d_ho), .q_out(t_ho));
  hbe_div #(.DW(DW), .NB(NB)) u_div_hc (.clk(clk), .en(en), .d_in(d_hc), .q_out(t_hc));
  hbe_div #(.DW(DW), .NB(NB)) u_div_nc (.clk(clk), .en(en), .d_in(d_nc), .q_out(t_nc));
  hbe_div #(.DW(DW), .NB(NB)) u_div_no (.clk(clk), .en(en), .d_in(d_no), .q_out(t_no));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      close_r <= {close_r[CL-2:0], close_nxt};
    end
  end

  // energy sum, round half up, clamp
  assign rnd = s_a_r + SW'(32'sd1 <<< (FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      s_a_r <= -signed'(SW'(t_ho)) + signed'(SW'(t_hc))
               - signed'(SW'(t_nc)) + signed'(SW'(t_no));
      e_b_r <= rnd[SW-1:FRAC_BITS];
    end
  end

  assign floor_ext = EW'(floor_r);

  always_comb begin
    e_sel = close_r[CL-1] ? floor_ext : e_b_r;
    e_fin = e_sel;
    if (e_sel <= floor_ext) begin
      e_fin = floor_ext;
    end
    if (e_fin > EW'(ENERGY_MAX)) begin
      e_fin = EW'(ENERGY_MAX);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (en && vld_r[LAT-1]) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld_r[LAT-1]) begin
      out_energy_r  <= e_fin[ENERGY_W-1:0];
      out_is_bond_r <= (e_fin <= EW'(cutoff_r));
    end
  end

  assign out_valid   = out_valid_r;
  assign out_energy  = out_energy_r;
  assign out_is_bond = out_is_bond_r;

`ifndef ASSERT_OFF
  a_close_floor: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[LAT-1] && close_r[CL-1] |=> out_energy == floor_r)
    else $error("too-close item did not give floor energy");

  a_bond_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_is_bond == (out_energy <= ENERGY_W'(cutoff_r)))
    else $error("bond flag disagrees with energy and cutoff");

  a_above_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_energy >= floor_r)
    else $error("energy below floor");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid_r && !out_ready && vld_r[LAT-1])
    else $error("input stalled without a blocked output");
`endif

endmodule

FILE: verif/backbone_hbond_energy_tb.sv
// Self-checking testbench for the backbone hydrogen-bond energy block.
`timescale 1ns / 1ps
module backbone_hbond_energy_tb;
  import hbe_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int TAIL_CYCLES = 100;

  typedef logic signed [CW-1:0] coord_t;
  // n xyz, h xyz, c xyz, o xyz
  typedef struct {
    coord_t p[12];
  } atoms_t;

  typedef struct {
    logic signed [ENERGY_W-1:0] energy;
    logic                       is_bond;
  } hbond_t;

  class hbond_scoreboard;
    longint          cutoff;
    longint          floor_e;
    longint unsigned min_dist;
    hbond_t          pending[$];
    int              fails;

    function new();
      cutoff   = CUTOFF_RST;
      floor_e  = FLOOR_RST;
      min_dist = MIN_DIST_RST;
      fails    = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CUTOFF:   cutoff = $signed(data[CUTOFF_W-1:0]);
        CFG_FLOOR:    floor_e = $signed(data[FLOOR_W-1:0]);
        CFG_MIN_DIST: min_dist = data[MIN_DIST_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned atom_dist(atoms_t a, int i, int j);
      longint unsigned sq;
      longint unsigned r;
      longint unsigned t;
      longint          d;
      sq = 0;
      for (int k = 0; k < 3; k++) begin
        d  = longint'(a.p[i+k]) - longint'(a.p[j+k]);
        sq += longint'(d * d);
      end
      r = 0;
      for (int b = 24; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= sq) r = t;
      end
      if (sq - r * r > r) r++;
      return r;
    endfunction

    function longint coulomb_term(longint unsigned d);
      return longint'((Q_NUM + d / 2) / d);
    endfunction

    function hbond_t bond_energy(atoms_t a);
      hbond_t          res;
      longint unsigned dho, dhc, dnc, dno;
      longint          s, e;
      dho = atom_dist(a, 3, 9);
      dhc = atom_dist(a, 3, 6);
      dnc = atom_dist(a, 0, 6);
      dno = atom_dist(a, 0, 9);
      if (dho == 0 || dhc == 0 || dnc == 0 || dno == 0 || dho < min_dist ||
          dhc < min_dist || dnc < min_dist || dno < min_dist) begin
        e = floor_e;
      end else begin
        s = -coulomb_term(dho) + coulomb_term(dhc) - coulomb_term(dnc) + coulomb_term(dno);
        e = (s + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      end
      if (e <= floor_e) e = floor_e;
      if (e > 32767) e = 32767;
      res.energy  = e[ENERGY_W-1:0];
      res.is_bond = (e <= cutoff);
      return res;
    endfunction

    function void note_item(atoms_t a);
      pending.push_back(bond_energy(a));
    endfunction

    function void check_result(logic signed [ENERGY_W-1:0] energy, logic is_bond);
      hbond_t want;
      if (pending.size() == 0) begin
        $error("unexpected result beat energy=%0d is_bond=%0b", energy, is_bond);
        fails++;
        return;
      end
      want = pending.pop_front();
      if (energy !== want.energy) begin
        $error("energy: expected %0d, got %0d", want.energy, energy);
        fails++;
      end
      if (is_bond !== want.is_bond) begin
        $error("is_bond: expected %0b, got %0b", want.is_bond, is_bond);
        fails++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, out_is_bond;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic signed [ENERGY_W-1:0] out_energy;
  atoms_t cur;
  hbond_scoreboard sb;
  int burst_left;
  int stall_mode;

  backbone_hbond_energy DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_n_x(cur.p[0]), .in_n_y(cur.p[1]), .in_n_z(cur.p[2]),
    .in_h_x(cur.p[3]), .in_h_y(cur.p[4]), .in_h_z(cur.p[5]),
    .in_c_x(cur.p[6]), .in_c_y(cur.p[7]), .in_c_z(cur.p[8]),
    .in_o_x(cur.p[9]), .in_o_y(cur.p[10]), .in_o_z(cur.p[11]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_energy(out_energy), .out_is_bond(out_is_bond),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("backbone_hbond_energy_tb NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_item(cur);
    if (rst_n && out_valid && out_ready) sb.check_result(out_energy, out_is_bond);
  end

  // receiver stall pattern, switching at random between four modes
  always @(negedge clk) begin
    if ($urandom_range(255) == 0) stall_mode <= $urandom_range(3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(1);
      2: out_ready <= ($urandom_range(3) == 0);
      default: out_ready <= ($urandom_range(15) != 0);
    endcase
  end

  task automatic send_atoms(atoms_t a);
    cur      = a;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid   = 1'b0;
      burst_left = $urandom_range(1, 40);
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic atoms_t line_atoms(int n, int h, int c, int o);
    atoms_t a;
    foreach (a.p[k]) a.p[k] = '0;
    a.p[0] = coord_t'(n);
    a.p[3] = coord_t'(h);
    a.p[6] = coord_t'(c);
    a.p[9] = coord_t'(o);
    return a;
  endfunction

  function automatic int jitter(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  task automatic send_directed();
    atoms_t a;
    foreach (a.p[k]) a.p[k] = '0;
    send_atoms(a);
    foreach (a.p[k]) a.p[k] = {1'b0, {(CW-1){1'b1}}};
    send_atoms(a);
    foreach (a.p[k]) a.p[k] = (k < 6) ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    send_atoms(a);
    send_atoms(line_atoms(0, 1000, 4130, 2900));
    send_atoms(line_atoms(0, 1000, 2500, 1300));
    send_atoms(line_atoms(0, 1000, 1001, 5000));
  endtask

  task automatic send_random(int count);
    atoms_t a;
    int base;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: foreach (a.p[k]) a.p[k] = coord_t'($urandom);
        1: begin
          base = $urandom;
          foreach (a.p[k]) a.p[k] = coord_t'(base + jitter(600));
        end
        default: begin
          for (int k = 0; k < 3; k++) begin
            a.p[k]   = coord_t'($urandom);
            a.p[k+3] = coord_t'(a.p[k] + jitter(1500));
            a.p[k+9] = coord_t'(a.p[k+3] + jitter(4000));
            a.p[k+6] = coord_t'(a.p[k+9] + jitter(2000));
          end
        end
      endcase
      send_atoms(a);
    end
  endtask

  initial begin
    sb         = new();
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    out_ready  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_CUTOFF;
    cfg_data   = '0;
    burst_left = 0;
    stall_mode = 0;
    foreach (cur.p[k]) cur.p[k] = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    send_directed();
    send_random(450);
    drain();

    write_reg(CFG_CUTOFF, -16'sd9900);
    write_reg(CFG_FLOOR, 16'h8000);
    write_reg(CFG_MIN_DIST, 16'd0);
    send_directed();
    send_random(450);
    drain();

    write_reg(CFG_CUTOFF, 16'd0);
    write_reg(CFG_FLOOR, 16'd0);
    write_reg(CFG_MIN_DIST, 16'd4095);
    send_directed();
    send_random(450);
    drain();

    write_reg(CFG_CUTOFF, 16'(-int'($urandom_range(9900))));
    write_reg(CFG_FLOOR, 16'(-int'($urandom_range(32768))));
    write_reg(CFG_MIN_DIST, 16'($urandom_range(1200)));
    send_directed();
    send_random(200);
    drain();
    send_random(250);

    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.fails == 0)
      $display("backbone_hbond_energy_tb OK");
    else
      $display("backbone_hbond_energy_tb NOT OK");
    $finish;
  end

endmodule
